>>> design/incremental_linear_xor_hash_assert.svh
// ----------------------------------------------------------------------------
// incremental linear xor hash assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef INCREMENTAL_LINEAR_XOR_HASH_ASSERT_SVH
`define INCREMENTAL_LINEAR_XOR_HASH_ASSERT_SVH

`ifndef SYNTHESIS

`define ILXH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ILXH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ILXH_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define ILXH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/ilxh_pkg.sv
// ----------------------------------------------------------------------------
// ilxh_pkg
// types and constants shared by the incremental linear xor hash
// ----------------------------------------------------------------------------
`default_nettype none

package ilxh_pkg;

    localparam int IDX_W          = 11;
    localparam int WORD_W         = 32;
    localparam int BYTE_W         = 8;
    localparam int VL_W           = 7;
    localparam int BIT_CNT_W      = 3;
    localparam int WORDS_PER_BIT  = 3;
    localparam int WORDS_PER_BYTE = 24;
    localparam int VLEN_RESET     = 64;

    // divide by three: q = (x * 683) >> 11, exact for x below 2048
    localparam int RECIP3         = 683;
    localparam int RECIP3_W       = 10;
    localparam int RECIP3_SHIFT   = 11;

    localparam logic MODE_MATRIX  = 1'b0;
    localparam logic MODE_HASH    = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [IDX_W-1:0]    matrix_index;
        logic [WORD_W-1:0]   matrix_word;
        logic [BYTE_W-1:0]   byte_value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]   key_low;
        logic [WORD_W-1:0]   key_mid;
        logic [WORD_W-1:0]   key_high;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/ilxh_ram.sv
// ----------------------------------------------------------------------------
// ilxh_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ilxh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/incremental_linear_xor_hash.sv
// ----------------------------------------------------------------------------
// incremental_linear_xor_hash
// differential 96-bit gf(2) linear hash of a byte vector
// ----------------------------------------------------------------------------
// A matrix write (mode 0) is taken while the block is idle, and the block can take
// another item in the very next cycle. A vector byte (mode 1) passes, from its
// transfer to the next possible transfer, through a load state that reads the stored
// old byte, a run state that walks the eight bits of the byte one per cycle, each
// step reading one word from each of three matrix rams (one per key word), a drain
// state that folds the last read into the key, a done state that updates the
// position and, after the last byte of a vector, loads the key into the output
// register, and an idle state in which the next item is taken. The update is held
// only while the output register still holds an untaken key. The old vector is
// tracked with a fill count, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "incremental_linear_xor_hash_assert.svh"

module incremental_linear_xor_hash #(
    parameter int MAX_BYTES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire ilxh_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output ilxh_pkg::out_item_t              out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [ilxh_pkg::VL_W-1:0]   cfg_data
);

    import ilxh_pkg::*;

    localparam int POS_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LEN_W     = $clog2(MAX_BYTES + 1);
    localparam int CMP_W     = (LEN_W > VL_W) ? LEN_W : VL_W;
    localparam int LANE_DEP  = MAX_BYTES * BYTE_W;
    localparam int ROW_W     = $clog2(LANE_DEP);
    localparam int MAT_DEPTH = MAX_BYTES * WORDS_PER_BYTE;
    localparam int PROD_W    = IDX_W + RECIP3_W;
    localparam int VLEN_RST  = (VLEN_RESET > MAX_BYTES) ? MAX_BYTES : VLEN_RESET;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [LEN_W-1:0]                vlen_reg, vlen_next;
    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [LEN_W-1:0]                fill_reg, fill_next;
    logic [BYTE_W-1:0]               nb_reg, nb_next;
    logic [BYTE_W-1:0]               diff_reg, diff_next;
    logic [BIT_CNT_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic                            pend_reg, pend_next;
    logic [WORDS_PER_BIT-1:0][WORD_W-1:0] key_reg, key_next;
    logic                            out_valid_reg, out_valid_next;
    out_item_t                       out_data_reg, out_data_next;

    logic                            in_xfer;
    logic                            mat_we;
    logic [PROD_W-1:0]               prod;
    logic [IDX_W-1:0]                row_full;
    logic [IDX_W-1:0]                rem_full;
    logic [1:0]                      lane;
    logic [ROW_W-1:0]                mat_waddr;
    logic [ROW_W-1:0]                mat_raddr;
    logic [WORDS_PER_BIT-1:0][WORD_W-1:0] mat_rdata;
    logic                            old_we;
    logic [BYTE_W-1:0]               old_rdata;
    logic [BYTE_W-1:0]               old_byte;
    logic [LEN_W-1:0]                pos_ext;
    logic [LEN_W-1:0]                pos_plus;
    logic [CMP_W-1:0]                cfg_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // matrix word address split into row and key lane
    assign prod      = PROD_W'(in_data.matrix_index) * PROD_W'(RECIP3);
    assign row_full  = IDX_W'(prod >> RECIP3_SHIFT);
    assign rem_full  = in_data.matrix_index - (row_full + (row_full << 1));
    assign lane      = rem_full[1:0];
    assign mat_waddr = ROW_W'(row_full);
    assign mat_we    = in_xfer && (in_data.mode == MODE_MATRIX)
                       && (32'(in_data.matrix_index) < 32'(MAT_DEPTH));
    assign mat_raddr = ROW_W'({pos_reg, bit_cnt_reg});

    genvar g;
    generate
        for (g = 0; g < WORDS_PER_BIT; g++)
        begin : g_lane
            ilxh_ram #(
                .WIDTH (WORD_W),
                .DEPTH (LANE_DEP)
            ) u_mat_ram (
                .clk   (clk),
                .we    (mat_we && (lane == 2'(g))),
                .waddr (mat_waddr),
                .wdata (in_data.matrix_word),
                .raddr (mat_raddr),
                .rdata (mat_rdata[g])
            );
        end
    endgenerate

    assign old_we = (state_reg == S_LOAD);

    ilxh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_old_ram (
        .clk   (clk),
        .we    (old_we),
        .waddr (pos_reg),
        .wdata (nb_reg),
        .raddr (pos_reg),
        .rdata (old_rdata)
    );

    assign pos_ext  = LEN_W'(pos_reg);
    assign pos_plus = pos_ext + LEN_W'(1);
    assign old_byte = (pos_ext < fill_reg) ? old_rdata : '0;
    assign cfg_ext  = CMP_W'(cfg_data);

    always_comb
    begin
        state_next     = state_reg;
        vlen_next      = vlen_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        nb_next        = nb_reg;
        diff_next      = diff_reg;
        bit_cnt_next   = bit_cnt_reg;
        pend_next      = 1'b0;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_data == '0)
            begin
                vlen_next = LEN_W'(1);
            end
            else if (cfg_ext > CMP_W'(MAX_BYTES))
            begin
                vlen_next = LEN_W'(MAX_BYTES);
            end
            else
            begin
                vlen_next = LEN_W'(cfg_data);
            end
        end

        // fold in the matrix triple read for the previous bit
        if (pend_reg)
        begin
            key_next = key_reg ^ mat_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_data.mode == MODE_HASH))
                begin
                    nb_next    = in_data.byte_value;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                diff_next    = old_byte ^ nb_reg;
                bit_cnt_next = '0;
                if (pos_ext == fill_reg)
                begin
                    fill_next = fill_reg + LEN_W'(1);
                end
                state_next = S_RUN;
            end
            S_RUN:
            begin
                pend_next    = diff_reg[0];
                diff_next    = diff_reg >> 1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == '1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (pos_plus >= vlen_reg)
                begin
                    if (!(out_valid_reg && out_stall))
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next.key_low  = key_reg[0];
                        out_data_next.key_mid  = key_reg[1];
                        out_data_next.key_high = key_reg[2];
                        pos_next               = '0;
                        state_next             = S_IDLE;
                    end
                end
                else
                begin
                    pos_next   = POS_W'(pos_plus);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vlen_reg      <= LEN_W'(VLEN_RST);
            pos_reg       <= '0;
            fill_reg      <= '0;
            bit_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vlen_reg      <= vlen_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            bit_cnt_reg   <= bit_cnt_next;
            pend_reg      <= pend_next;
            key_reg       <= key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg       <= nb_next;
        diff_reg     <= diff_next;
        out_data_reg <= out_data_next;
    end

    `ILXH_ASSERT_SAME(a_pos_below_len, clk, rst_n, state_reg == S_LOAD, pos_ext <= fill_reg)
    `ILXH_ASSERT_SAME(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= LEN_W'(MAX_BYTES))
    `ILXH_ASSERT_NEXT(a_run_length, clk, rst_n,
                      (state_reg == S_RUN) && (bit_cnt_reg != '1), state_reg == S_RUN)
    `ILXH_ASSERT_SAME(a_emit_from_done, clk, rst_n,
                      $rose(out_valid_reg), $past(state_reg) == S_DONE)

endmodule

`default_nettype wire

>>> verif/incremental_linear_xor_hash_test.sv
// ----------------------------------------------------------------------------
// incremental_linear_xor_hash_test
// fills the hash matrix, then streams vector bytes and matrix updates through
// the block under several vector lengths with random gaps and output stalls;
// every key transfer is checked against an in-order model of the hash
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_linear_xor_hash_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ilxh_pkg::*;

    localparam int MAX_BYTES     = 64;
    localparam int MATRIX_DEPTH  = MAX_BYTES * WORDS_PER_BYTE;
    localparam int INDEX_TOP     = (1 << IDX_W) - 1;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    class hash_scoreboard;
        logic [WORD_W-1:0] matrix [MATRIX_DEPTH];
        logic [BYTE_W-1:0] old_bytes [MAX_BYTES];
        logic [WORD_W-1:0] key_a;
        logic [WORD_W-1:0] key_b;
        logic [WORD_W-1:0] key_c;
        int unsigned       position;
        logic [VL_W-1:0]   vector_length;
        out_item_t         expected_keys [$];
        int unsigned       errors;
        int unsigned       keys_seen;

        function new();
            foreach (old_bytes[i])
                old_bytes[i] = '0;
            key_a         = '0;
            key_b         = '0;
            key_c         = '0;
            position      = 0;
            vector_length = VL_W'(VLEN_RESET);
            errors        = 0;
            keys_seen     = 0;
        endfunction

        function void note_item(in_item_t item);
            int unsigned       span;
            int unsigned       row;
            logic [BYTE_W-1:0] diff;
            out_item_t         key;
            if (item.mode == MODE_MATRIX)
            begin
                if (item.matrix_index < MATRIX_DEPTH)
                    matrix[item.matrix_index] = item.matrix_word;
                return;
            end
            span = vector_length;
            if (span < 1)
                span = 1;
            if (span > MAX_BYTES)
                span = MAX_BYTES;
            diff = old_bytes[position] ^ item.byte_value;
            row  = position * WORDS_PER_BYTE;
            for (int b = 0; b < BYTE_W; b++)
            begin
                if (diff[b])
                begin
                    key_a ^= matrix[row + b * WORDS_PER_BIT];
                    key_b ^= matrix[row + b * WORDS_PER_BIT + 1];
                    key_c ^= matrix[row + b * WORDS_PER_BIT + 2];
                end
            end
            old_bytes[position] = item.byte_value;
            position++;
            if (position >= span)
            begin
                position     = 0;
                key.key_low  = key_a;
                key.key_mid  = key_b;
                key.key_high = key_c;
                expected_keys.push_back(key);
            end
        endfunction

        function void check_key(out_item_t got);
            out_item_t want;
            keys_seen++;
            if (expected_keys.size() == 0)
            begin
                $error("key transfer with none expected: %h", got);
                errors++;
                return;
            end
            want = expected_keys.pop_front();
            if (got.key_low !== want.key_low)
            begin
                $error("key_low: expected %h, actual %h", want.key_low, got.key_low);
                errors++;
            end
            if (got.key_mid !== want.key_mid)
            begin
                $error("key_mid: expected %h, actual %h", want.key_mid, got.key_mid);
                errors++;
            end
            if (got.key_high !== want.key_high)
            begin
                $error("key_high: expected %h, actual %h", want.key_high, got.key_high);
                errors++;
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    in_item_t        in_data;
    logic            out_valid;
    logic            out_stall;
    out_item_t       out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [VL_W-1:0] cfg_data;
    hash_scoreboard  sb;
    int unsigned     cycles = 0;

    incremental_linear_xor_hash #(
        .MAX_BYTES(MAX_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(bit burst);
        if (burst)
            return 0;
        case ($urandom_range(0, 19))
            10, 11, 12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
            18: return $urandom_range(4, 10);
            19: return $urandom_range(20, 60);
            default: return 0;
        endcase
    endfunction

    function automatic in_item_t matrix_item(int unsigned index, logic [WORD_W-1:0] word);
        in_item_t item;
        item.mode         = MODE_MATRIX;
        item.matrix_index = IDX_W'(index);
        item.matrix_word  = word;
        item.byte_value   = BYTE_W'($urandom());
        return item;
    endfunction

    function automatic in_item_t hash_item(logic [BYTE_W-1:0] value);
        in_item_t item;
        item.mode         = MODE_HASH;
        item.matrix_index = IDX_W'($urandom());
        item.matrix_word  = $urandom();
        item.byte_value   = value;
        return item;
    endfunction

    // valid stays high across back-to-back transfers
    task automatic push_item(in_item_t item, int unsigned gap);
        in_data  <= item;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(item);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_keys.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [VL_W-1:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.vector_length = value;
    endtask

    // output side: random stall runs plus one long hold to back up the block
    initial
    begin : receiver
        int unsigned run_left;
        bit          stalling;
        bit          held;
        run_left  = 0;
        stalling  = 1'b0;
        held      = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_key(out_data);
            if (run_left == 0)
            begin
                if (!held && sb.keys_seen >= 6)
                begin
                    held     = 1'b1;
                    stalling = 1'b1;
                    run_left = LONG_HOLD;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        5, 6, 7, 8:
                        begin
                            stalling = 1'b1;
                            run_left = $urandom_range(1, 4);
                        end
                        9:
                        begin
                            stalling = 1'b1;
                            run_left = $urandom_range(20, 60);
                        end
                        default:
                        begin
                            stalling = 1'b0;
                            run_left = $urandom_range(1, 40);
                        end
                    endcase
                end
            end
            run_left--;
            out_stall <= stalling;
        end
    end

    initial
    begin : stimulus
        logic [VL_W-1:0]   lengths [10];
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] value;
        int unsigned       span;
        int unsigned       count;
        int unsigned       pick;
        bit                burst;
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the whole matrix is written before any byte reads it
        for (int i = 0; i < MATRIX_DEPTH; i++)
            push_item(matrix_item(i, $urandom()), pick_gap(1'b0));

        // directed: edge indexes and words, then bytes at the reset length
        push_item(matrix_item(MATRIX_DEPTH, '1), pick_gap(1'b0));
        push_item(matrix_item(INDEX_TOP, '0), pick_gap(1'b0));
        push_item(matrix_item(0, '1), pick_gap(1'b0));
        push_item(matrix_item(1, '0), pick_gap(1'b0));
        push_item(matrix_item(MATRIX_DEPTH - 1, 32'h8000_0001), pick_gap(1'b0));
        push_item(hash_item(8'hff), pick_gap(1'b0));
        push_item(hash_item(8'h00), pick_gap(1'b0));
        push_item(hash_item(8'h80), pick_gap(1'b0));
        push_item(hash_item(8'h01), pick_gap(1'b0));
        push_item(hash_item(8'haa), pick_gap(1'b0));
        push_item(hash_item(8'h55), pick_gap(1'b0));
        push_item(hash_item(8'hff), pick_gap(1'b0));
        for (int i = 0; i < 5; i++)
            push_item(hash_item(BYTE_W'($urandom())), pick_gap(1'b0));
        // shorten the vector past the current position
        write_length(7'd5);
        push_item(hash_item(8'h3c), pick_gap(1'b0));
        push_item(hash_item(8'h00), pick_gap(1'b0));

        lengths = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd7, 7'd0, 7'd3, 7'd64, 7'd0};
        lengths[6] = VL_W'($urandom_range(4, 20));
        lengths[9] = VL_W'($urandom_range(8, 40));

        for (int p = 0; p < 10; p++)
        begin
            write_length(lengths[p]);
            span = lengths[p];
            if (span < 1)
                span = 1;
            count = (span >= MAX_BYTES) ? 140 : 70;
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < count; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 12)
                    push_item(matrix_item($urandom_range(0, MATRIX_DEPTH - 1), $urandom()),
                              pick_gap(burst));
                else if (pick < 16)
                    push_item(matrix_item($urandom_range(MATRIX_DEPTH, INDEX_TOP), $urandom()),
                              pick_gap(burst));
                else
                begin
                    prev = sb.old_bytes[sb.position];
                    case ($urandom_range(0, 7))
                        0: value = prev;
                        1: value = ~prev;
                        default: value = BYTE_W'($urandom_range(0, 255));
                    endcase
                    push_item(hash_item(value), pick_gap(burst));
                end
            end
        end

        settle();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> incremental_linear_xor_hash.f
+incdir+design
design/ilxh_pkg.sv
design/ilxh_ram.sv
design/incremental_linear_xor_hash.sv
verif/incremental_linear_xor_hash_test.sv
